// ===== rtl/gsae_pkg.sv =====
// Shared constants, codes and types of the gather/scatter/add engine.
package gsae_pkg;

   localparam int MAX_CLASSES = 256;
   localparam int MAX_ROW     = 16;
   localparam int DATA_WIDTH  = 32;

   localparam int TABLE_DEPTH = MAX_CLASSES * MAX_ROW;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ROW_W       = $clog2(MAX_CLASSES);

   localparam int ROW_IDX_W   = 32;
   localparam int COLUMN_W    = 4;
   localparam int KIND_W      = 2;
   localparam int ROW_LEN_W   = 5;
   localparam int CLASS_CNT_W = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROCESS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCATTER_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCUMULATE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_COUNT  = 2'd3;

   localparam logic [ROW_LEN_W-1:0]   ROW_LENGTH_RESET  = ROW_LEN_W'(MAX_ROW);
   localparam logic [CLASS_CNT_W-1:0] CLASS_COUNT_RESET = CLASS_CNT_W'(MAX_CLASSES);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [ADDR_W-1:0]     addr_type;

   typedef struct packed {
      logic load_item;
      logic read_mem;
      logic commit;
   } gsae_cmd_type;

endpackage

// ===== rtl/gsae_ctrl.sv =====
// Controller state machine: sequences capture, table read and commit of one beat.
module gsae_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output gsae_pkg::gsae_cmd_type cmd
);
   import gsae_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign cmd.load_item = (state_ff == ST_IDLE) && start;
   assign cmd.read_mem  = (state_ff == ST_READ);
   assign cmd.commit    = (state_ff == ST_EXEC);

endmodule

// ===== rtl/gsae_dp.sv =====
// Datapath: configuration registers, element table, adder and result registers.
module gsae_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  gsae_pkg::gsae_cmd_type              cmd,
   input  logic                                csr_write,
   input  logic [gsae_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gsae_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [gsae_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [gsae_pkg::ROW_IDX_W-1:0] req_row_index,
   input  logic [gsae_pkg::COLUMN_W-1:0]       req_column,
   input  logic signed [gsae_pkg::DATA_WIDTH-1:0] req_value,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic signed [gsae_pkg::DATA_WIDTH-1:0] rsp_result,
   output logic                                rsp_out_of_range,
   output logic                                rsp_batch_error,
   output logic                                rsp_last_out
);
   import gsae_pkg::*;

   logic                   scatter_mode_ff;
   logic                   accumulate_ff;
   logic [ROW_LEN_W-1:0]   row_length_ff;
   logic [CLASS_CNT_W-1:0] class_count_ff;

   logic [CLASS_CNT_W-1:0] class_lim;
   logic [ROW_LEN_W-1:0]   row_lim;
   logic                   valid_in;
   addr_type               addr_in;

   logic [KIND_W-1:0] kind_ff;
   logic              valid_ff;
   addr_type          addr_ff;
   data_type          value_ff;
   logic              last_ff;
   data_type          rdata_ff;

   data_type mem [TABLE_DEPTH];

   data_type sum;
   data_type result_in;
   logic     oor_in;
   logic     wr_en;
   data_type wdata;

   logic     error_seen_ff;
   logic     error_seen_in;
   logic     rsp_valid_ff;
   data_type rsp_result_ff;
   logic     rsp_oor_ff;
   logic     rsp_berr_ff;
   logic     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scatter_mode_ff <= 1'b0;
         accumulate_ff   <= 1'b0;
         row_length_ff   <= ROW_LENGTH_RESET;
         class_count_ff  <= CLASS_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCATTER_MODE: scatter_mode_ff <= csr_data[0];
            CSR_ACCUMULATE:   accumulate_ff   <= csr_data[0];
            CSR_ROW_LENGTH:   row_length_ff   <= csr_data[ROW_LEN_W-1:0];
            CSR_CLASS_COUNT:  class_count_ff  <= csr_data[CLASS_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp sizes, then check row and column of the incoming beat.
   always_comb begin
      class_lim = (class_count_ff > CLASS_CNT_W'(MAX_CLASSES)) ?
                  CLASS_CNT_W'(MAX_CLASSES) : class_count_ff;
      row_lim   = (row_length_ff > ROW_LEN_W'(MAX_ROW)) ? ROW_LEN_W'(MAX_ROW) : row_length_ff;
      valid_in  = !req_row_index[ROW_IDX_W-1]
                  && (req_row_index[ROW_IDX_W-2:0] < (ROW_IDX_W-1)'(class_lim))
                  && ({1'b0, req_column} < row_lim);
      addr_in   = ADDR_W'(ADDR_W'(req_row_index[ROW_W-1:0]) * ADDR_W'(MAX_ROW))
                  + ADDR_W'(req_column);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff  <= req_kind;
         valid_ff <= valid_in;
         addr_ff  <= addr_in;
         value_ff <= req_value;
         last_ff  <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_mem) begin
         rdata_ff <= mem[addr_ff];
      end
      if (wr_en) begin
         mem[addr_ff] <= wdata;
      end
   end

   always_comb begin
      sum       = rdata_ff + value_ff;
      result_in = '0;
      oor_in    = 1'b0;
      wr_en     = 1'b0;
      wdata     = value_ff;
      case (kind_ff)
         KIND_LOAD: begin
            oor_in    = !valid_ff;
            wr_en     = cmd.commit && valid_ff;
            result_in = valid_ff ? value_ff : '0;
         end
         KIND_PROCESS: begin
            oor_in = !valid_ff;
            if (scatter_mode_ff) begin
               wdata = accumulate_ff ? sum : value_ff;
               wr_en = cmd.commit && valid_ff;
               result_in = valid_ff ? wdata : '0;
            end else begin
               result_in = valid_ff ? (accumulate_ff ? sum : rdata_ff) : '0;
            end
         end
         KIND_READ: begin
            oor_in    = !valid_ff;
            result_in = valid_ff ? rdata_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      error_seen_in = error_seen_ff;
      if (cmd.commit) begin
         error_seen_in = last_ff ? 1'b0 : (error_seen_ff | oor_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         error_seen_ff <= error_seen_in;
         rsp_valid_ff  <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_result_ff <= result_in;
         rsp_oor_ff    <= oor_in;
         rsp_berr_ff   <= last_ff && (error_seen_ff || oor_in);
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = rsp_result_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_batch_error  = rsp_berr_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule

// ===== rtl/gather_scatter_add_engine_top.sv =====
// Top level of the gather/scatter/add engine: controller, datapath and checks.
//
// Usage:
//   Request channel: drive req_* and raise start; a beat is taken at a rising
//   edge with start high and busy low. kind 0 loads a table element, kind 1
//   gathers or scatters per the mode registers, kind 2 reads an element back.
//   Response channel: rsp_valid is high for exactly one cycle with the result
//   fields; the receiver cannot stall, so it must take the beat in that cycle.
//   CSR channel: csr_ready is always high; write csr_index/csr_data with
//   csr_valid only while no request is in flight.
//   Sequence: an accepted beat is captured, the table is read, the result is
//   committed and then registered onto the rsp_* outputs with rsp_valid.
//   A new request is taken only after the previous one has committed, owing
//   to the registered read of the single-port table and its write-back.
//   Reset: synchronous, active high; clears the mode registers to their
//   defaults, the sticky batch error and the sequencer. The table is not
//   cleared and must be loaded before it is read.
module gather_scatter_add_engine_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [gsae_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [gsae_pkg::ROW_IDX_W-1:0] req_row_index,
   input  logic [gsae_pkg::COLUMN_W-1:0]         req_column,
   input  logic signed [gsae_pkg::DATA_WIDTH-1:0] req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   output logic signed [gsae_pkg::DATA_WIDTH-1:0] rsp_result,
   output logic                                  rsp_out_of_range,
   output logic                                  rsp_batch_error,
   output logic                                  rsp_last_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gsae_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gsae_pkg::CSR_DATA_W-1:0]       csr_data
);
   import gsae_pkg::*;

   gsae_cmd_type cmd;

   assign csr_ready = 1'b1;

   gsae_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   gsae_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_kind         (req_kind),
      .req_row_index    (req_row_index),
      .req_column       (req_column),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_result       (rsp_result),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_batch_error  (rsp_batch_error),
      .rsp_last_out     (rsp_last_out)
   );

   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit))
      else $error("response beat without a commit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid) ##1 (busy && !rsp_valid) ##1 rsp_valid)
      else $error("accepted beat not sequenced to one response");

   a_oor_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_result == '0))
      else $error("invalid beat returned nonzero data");

   a_berr_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_batch_error) |-> rsp_last_out)
      else $error("batch error outside last beat");

endmodule

// ===== verif/gather_scatter_add_engine_top_tb.sv =====
// Self-checking testbench of the gather/scatter/add engine: table predictor, stimulus, checks.
`timescale 1ns / 1ps

import gsae_pkg::*;

localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

typedef struct {
   logic [KIND_W-1:0]            kind;
   logic signed [ROW_IDX_W-1:0]  row_index;
   logic [COLUMN_W-1:0]          column;
   logic signed [DATA_WIDTH-1:0] value;
   logic                         last;
} request_beat_type;

typedef struct {
   logic signed [DATA_WIDTH-1:0] result;
   logic                         out_of_range;
   logic                         batch_error;
   logic                         last_out;
} response_beat_type;

function automatic bit beat_in_range(request_beat_type req, logic [ROW_LEN_W-1:0] row_length,
                                     logic [CLASS_CNT_W-1:0] class_count);
   int unsigned rows;
   int unsigned cols;
   rows = (class_count > MAX_CLASSES) ? MAX_CLASSES : class_count;
   cols = (row_length > MAX_ROW) ? MAX_ROW : row_length;
   return !req.row_index[ROW_IDX_W-1] && $unsigned(req.row_index) < rows && req.column < cols;
endfunction

function automatic addr_type beat_slot(request_beat_type req);
   return addr_type'(req.row_index[ROW_W-1:0] * MAX_ROW + req.column);
endfunction

class table_scoreboard;
   data_type               elements [TABLE_DEPTH];
   bit                     error_seen;
   bit                     scatter_mode;
   bit                     accumulate;
   logic [ROW_LEN_W-1:0]   row_length;
   logic [CLASS_CNT_W-1:0] class_count;
   response_beat_type      expected_beats[$];
   int unsigned            mismatch_count;

   function new();
      error_seen     = 1'b0;
      scatter_mode   = 1'b0;
      accumulate     = 1'b0;
      row_length     = ROW_LENGTH_RESET;
      class_count    = CLASS_COUNT_RESET;
      mismatch_count = 0;
   endfunction

   function void note_config(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_SCATTER_MODE: scatter_mode = data[0];
         CSR_ACCUMULATE:   accumulate   = data[0];
         CSR_ROW_LENGTH:   row_length   = data[ROW_LEN_W-1:0];
         CSR_CLASS_COUNT:  class_count  = data[CLASS_CNT_W-1:0];
         default: ;
      endcase
   endfunction

   function void note_request(request_beat_type req);
      response_beat_type rsp;
      addr_type          slot;
      rsp.result       = '0;
      rsp.out_of_range = 1'b0;
      rsp.batch_error  = 1'b0;
      rsp.last_out     = req.last;
      slot = beat_slot(req);
      if (req.kind != KIND_UNUSED) begin
         if (!beat_in_range(req, row_length, class_count)) begin
            rsp.out_of_range = 1'b1;
            error_seen = 1'b1;
         end else begin
            case (req.kind)
               KIND_LOAD: begin
                  elements[slot] = req.value;
                  rsp.result = req.value;
               end
               KIND_READ: rsp.result = elements[slot];
               default: begin
                  if (scatter_mode) begin
                     elements[slot] = accumulate ? elements[slot] + req.value : req.value;
                     rsp.result = elements[slot];
                  end else begin
                     rsp.result = accumulate ? req.value + elements[slot] : elements[slot];
                  end
               end
            endcase
         end
      end
      if (req.last) begin
         rsp.batch_error = error_seen;
         error_seen = 1'b0;
      end
      expected_beats.push_back(rsp);
   endfunction

   function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                               logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function void check_response(response_beat_type got);
      response_beat_type want;
      if (expected_beats.size() == 0) begin
         $display("%0t: response beat expected none actual result %h", $time, got.result);
         mismatch_count++;
         return;
      end
      want = expected_beats.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("out_of_range", DATA_WIDTH'(want.out_of_range),
                    DATA_WIDTH'(got.out_of_range));
      compare_field("batch_error", DATA_WIDTH'(want.batch_error),
                    DATA_WIDTH'(got.batch_error));
      compare_field("last_out", DATA_WIDTH'(want.last_out), DATA_WIDTH'(got.last_out));
   endfunction
endclass

module gather_scatter_add_engine_top_tb;
   localparam int RANDOM_ITEMS = 1450;
   localparam int NUM_PHASES   = 15;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [KIND_W-1:0]             req_kind = '0;
   logic signed [ROW_IDX_W-1:0]   req_row_index = '0;
   logic [COLUMN_W-1:0]           req_column = '0;
   logic signed [DATA_WIDTH-1:0]  req_value = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic signed [DATA_WIDTH-1:0]  rsp_result;
   logic                          rsp_out_of_range;
   logic                          rsp_batch_error;
   logic                          rsp_last_out;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   bit                            cfg_scatter = 1'b0;
   bit                            cfg_accumulate = 1'b0;
   logic [ROW_LEN_W-1:0]          cfg_row_length = ROW_LENGTH_RESET;
   logic [CLASS_CNT_W-1:0]        cfg_class_count = CLASS_COUNT_RESET;
   bit                            loaded [TABLE_DEPTH];
   addr_type                      recent_slots[$];
   int unsigned                   sender_idle_pct = 0;

   table_scoreboard table_sb = new();

   gather_scatter_add_engine_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1)
         table_sb.check_response('{rsp_result, rsp_out_of_range, rsp_batch_error, rsp_last_out});
   end

   // Turn reads of never-written slots into loads and track what the table holds.
   function automatic request_beat_type make_legal(request_beat_type req);
      addr_type slot;
      bit       in_range;
      bit       reads;
      slot = beat_slot(req);
      in_range = beat_in_range(req, cfg_row_length, cfg_class_count);
      reads = req.kind == KIND_READ ||
              (req.kind == KIND_PROCESS && !(cfg_scatter && !cfg_accumulate));
      if (in_range && reads && !loaded[slot])
         req.kind = KIND_LOAD;
      if (in_range && (req.kind == KIND_LOAD || (req.kind == KIND_PROCESS && cfg_scatter)))
         loaded[slot] = 1'b1;
      if (in_range && req.kind != KIND_UNUSED) begin
         recent_slots.push_back(slot);
         if (recent_slots.size() > 6)
            void'(recent_slots.pop_front());
      end
      return req;
   endfunction

   function automatic request_beat_type random_request();
      request_beat_type req;
      int unsigned      rows;
      int unsigned      cols;
      int unsigned      pick;
      addr_type         slot;
      rows = (cfg_class_count > MAX_CLASSES) ? MAX_CLASSES : cfg_class_count;
      cols = (cfg_row_length > MAX_ROW) ? MAX_ROW : cfg_row_length;
      pick = $urandom_range(99);
      req.kind = (pick < 25) ? KIND_LOAD : (pick < 75) ? KIND_PROCESS :
                 (pick < 93) ? KIND_READ : KIND_UNUSED;
      req.value = $urandom;
      req.last = ($urandom_range(7) == 0);
      req.column = COLUMN_W'($urandom_range(15));
      req.row_index = $urandom;
      pick = $urandom_range(99);
      if (pick < 6) begin
         // keep the wild row
      end else if (pick < 9) begin
         req.row_index = ~ROW_IDX_W'($urandom_range(2));
      end else if (pick < 12) begin
         req.row_index = rows;
      end else if (pick < 50 && recent_slots.size() != 0) begin
         slot = recent_slots[$urandom_range(recent_slots.size() - 1)];
         req.row_index = slot / MAX_ROW;
         req.column = COLUMN_W'(slot % MAX_ROW);
      end else if (rows != 0) begin
         req.row_index = $urandom_range(rows - 1);
         if (pick < 94 && cols != 0)
            req.column = COLUMN_W'($urandom_range(cols - 1));
      end
      return make_legal(req);
   endfunction

   task automatic send_beat(input request_beat_type req);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= req.kind;
      req_row_index <= req.row_index;
      req_column    <= req.column;
      req_value     <= req.value;
      req_last      <= req.last;
      do @(posedge clock); while (busy !== 1'b0);
      table_sb.note_request(req);
   endtask

   task automatic send_fields(input logic [KIND_W-1:0] kind,
                              input logic signed [ROW_IDX_W-1:0] row_index,
                              input logic [COLUMN_W-1:0] column,
                              input logic signed [DATA_WIDTH-1:0] value,
                              input logic last);
      request_beat_type req;
      req = '{kind, row_index, column, value, last};
      send_beat(make_legal(req));
   endtask

   // Hold off the sender until every expected beat has come back.
   task automatic drain();
      start <= 1'b0;
      while (table_sb.expected_beats.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      table_sb.note_config(index, data);
   endtask

   task automatic set_config(input bit scatter, input bit accum,
                             input logic [ROW_LEN_W-1:0] row_len,
                             input logic [CLASS_CNT_W-1:0] class_cnt);
      logic [CSR_DATA_W-1:0] noise;
      drain();
      noise = $urandom;
      write_csr(CSR_SCATTER_MODE, {noise[CSR_DATA_W-1:1], scatter});
      noise = $urandom;
      write_csr(CSR_ACCUMULATE, {noise[CSR_DATA_W-1:1], accum});
      noise = $urandom;
      write_csr(CSR_ROW_LENGTH, {noise[CSR_DATA_W-1:ROW_LEN_W], row_len});
      noise = $urandom;
      write_csr(CSR_CLASS_COUNT, {noise[CSR_DATA_W-1:CLASS_CNT_W], class_cnt});
      csr_valid <= 1'b0;
      cfg_scatter     = scatter;
      cfg_accumulate  = accum;
      cfg_row_length  = row_len;
      cfg_class_count = class_cnt;
   endtask

   initial begin
      int unsigned phase_items;
      int unsigned sent;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_fields(KIND_LOAD, 0, 0, 32'h7fff_ffff, 1'b0);
      send_fields(KIND_LOAD, 255, 15, 32'h8000_0000, 1'b0);
      send_fields(KIND_LOAD, 1, 3, 32'hffff_ffff, 1'b0);
      send_fields(KIND_READ, 0, 0, 0, 1'b0);
      send_fields(KIND_READ, 255, 15, 0, 1'b0);
      send_fields(KIND_PROCESS, 1, 3, 5, 1'b0);
      send_fields(KIND_READ, 32'hffff_ffff, 0, 0, 1'b0);
      send_fields(KIND_LOAD, 256, 0, 32'h0000_1234, 1'b0);
      send_fields(KIND_PROCESS, 32'h7fff_ffff, 15, 0, 1'b0);
      send_fields(KIND_LOAD, 32'h8000_0000, 0, 0, 1'b1);
      send_fields(KIND_UNUSED, 0, 0, 0, 1'b1);
      send_fields(KIND_LOAD, 0, 15, 1, 1'b1);
      set_config(1'b0, 1'b1, 16, 256);
      send_fields(KIND_PROCESS, 0, 0, 1, 1'b0);
      send_fields(KIND_PROCESS, 255, 15, 32'h8000_0000, 1'b1);
      set_config(1'b1, 1'b1, 16, 256);
      send_fields(KIND_PROCESS, 0, 0, 1, 1'b0);
      send_fields(KIND_PROCESS, 0, 0, 1, 1'b0);
      send_fields(KIND_READ, 0, 0, 0, 1'b1);
      set_config(1'b1, 1'b0, 16, 256);
      send_fields(KIND_PROCESS, 2, 0, 32'h1234_5678, 1'b0);
      send_fields(KIND_READ, 2, 0, 0, 1'b0);
      set_config(1'b0, 1'b0, 1, 1);
      send_fields(KIND_READ, 0, 1, 0, 1'b0);
      send_fields(KIND_READ, 1, 0, 0, 1'b0);
      send_fields(KIND_READ, 0, 0, 0, 1'b1);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         phase_items = 107;
         case (phase)
            0: set_config(1'b0, 1'b0, 16, 256);
            1: set_config(1'b1, 1'b1, 16, 3);
            2: set_config(1'b0, 1'b1, 7, 40);
            3: set_config(1'b1, 1'b0, 1, 1);
            4: set_config(1'b1, 1'b1, 31, 511);
            5: begin
               set_config(1'b0, 1'b0, 0, 256);
               phase_items = 30;
            end
            6: begin
               set_config(1'b1, 1'b1, 16, 0);
               phase_items = 30;
            end
            7: set_config(1'b0, 1'b1, 16, 2);
            8: set_config(1'b1, 1'b1, 2, 2);
            default: set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                ROW_LEN_W'($urandom_range(1, 16)),
                                ($urandom_range(2) == 0) ? CLASS_CNT_W'(256) :
                                CLASS_CNT_W'($urandom_range(1, 12)));
         endcase
         for (int i = 0; i < phase_items; i++) begin
            sender_idle_pct = (sent < RANDOM_ITEMS / 3) ? 23 :
                              (sent < 2 * RANDOM_ITEMS / 3) ? 79 : 0;
            if ($urandom_range(149) == 0)
               drain();
            send_beat(random_request());
            sent++;
         end
      end

      drain();
      if (table_sb.mismatch_count == 0 && table_sb.expected_beats.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
